/* sv/sha1md_pkg.sv */
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types, constants and round functions for the SHA-1 digest core.
// ----------------------------------------------------------------------------
package sha1md_pkg;

	// Command queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// Request kinds after classification
	localparam logic [1:0] CMD_NONE     = 2'd0;
	localparam logic [1:0] CMD_BYTE     = 2'd1;
	localparam logic [1:0] CMD_BYTE_END = 2'd2;
	localparam logic [1:0] CMD_END      = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} cmd_t;

	// Round phases, twenty rounds each
	localparam logic [1:0] PH_CH  = 2'd0;
	localparam logic [1:0] PH_PAR = 2'd1;
	localparam logic [1:0] PH_MAJ = 2'd2;
	localparam logic [1:0] PH_PR2 = 2'd3;

	localparam int    ROUNDS   = 80;
	localparam int    RND_W    = 7;
	localparam int    BLK_W    = 16;
	localparam int    CNT_W    = 61;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Initial chaining values, entry 4 first in the list, entry 0 last
	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	// Control from the sequencer to the round datapath
	typedef struct packed {
		logic       init;
		logic       load;
		logic       step;
		logic       add;
		logic [1:0] phase;
	} rnd_ctl_t;

	function automatic logic [31:0] round_k(input logic [1:0] phase);
		logic [31:0] k;
		case (phase)
			PH_CH:   k = 32'h5A827999;
			PH_PAR:  k = 32'h6ED9EBA1;
			PH_MAJ:  k = 32'h8F1BBCDC;
			default: k = 32'hCA62C1D6;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [1:0] phase,
		input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (phase)
			PH_CH:   f = d ^ (b & (c ^ d));
			PH_MAJ:  f = (b & c) | (d & (b | c));
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

endpackage

/* sv/sha1md_front.sv */
// ----------------------------------------------------------------------------
// sha1md_front
// Accepts message items, classifies them and queues requests for the back.
// ----------------------------------------------------------------------------
module sha1md_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_stall,
	input  logic [7:0]          data_byte,
	input  logic                byte_valid,
	input  logic                end_of_message,
	output sha1md_pkg::cmd_t    head,
	output logic                empty,
	input  logic                pop
);

	sha1md_pkg::cmd_t                  mem_q [sha1md_pkg::Q_DEPTH];
	logic [sha1md_pkg::Q_AW-1:0]       wr_q;
	logic [sha1md_pkg::Q_AW-1:0]       rd_q;
	logic [sha1md_pkg::Q_CW-1:0]       cnt_q;
	logic                              full;
	logic                              push;
	logic                              do_pop;
	logic [1:0]                        kind;

	// Classify the incoming item
	always_comb begin
		case ({byte_valid, end_of_message})
			2'b10:   kind = sha1md_pkg::CMD_BYTE;
			2'b11:   kind = sha1md_pkg::CMD_BYTE_END;
			2'b01:   kind = sha1md_pkg::CMD_END;
			default: kind = sha1md_pkg::CMD_NONE;
		endcase
	end

	assign full      = (cnt_q == sha1md_pkg::Q_CW'(sha1md_pkg::Q_DEPTH));
	assign empty     = (cnt_q == '0);
	assign msg_stall = full;
	// Drop items that carry neither a byte nor an end mark
	assign push      = msg_valid && !full && (kind != sha1md_pkg::CMD_NONE);
	assign do_pop    = pop && !empty;
	assign head      = mem_q[rd_q];

	// Store requests
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{kind: kind, data: data_byte};
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/sha1md_round.sv */
// ----------------------------------------------------------------------------
// sha1md_round
// SHA-1 round datapath: working variables, one round a cycle, chaining words.
// ----------------------------------------------------------------------------
module sha1md_round (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1md_pkg::rnd_ctl_t ctl,
	input  logic [31:0]          w,
	output logic [4:0][31:0]     chain
);

	logic [31:0]      a_q, b_q, c_q, d_q, e_q;
	logic [4:0][31:0] chain_q;
	logic [31:0]      t_sum;

	// One round of the compression function
	assign t_sum = {a_q[26:0], a_q[31:27]}
		+ sha1md_pkg::round_f(ctl.phase, b_q, c_q, d_q)
		+ e_q + sha1md_pkg::round_k(ctl.phase) + w;

	// Load or advance the working variables
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (ctl.step) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// Fold the block result into the chain, or restart it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= sha1md_pkg::H_INIT;
		end else if (ctl.init) begin
			chain_q <= sha1md_pkg::H_INIT;
		end else if (ctl.add) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end
	end

	assign chain = chain_q;

endmodule

/* sv/sha1md_back.sv */
// ----------------------------------------------------------------------------
// sha1md_back
// Sequencer: gathers bytes into the block window, pads, runs the rounds
// and hands out the digest words through an output register.
// ----------------------------------------------------------------------------
module sha1md_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1md_pkg::cmd_t     head,
	input  logic                 empty,
	output logic                 pop,
	output sha1md_pkg::rnd_ctl_t ctl,
	output logic [31:0]          w,
	input  logic [4:0][31:0]     chain,
	output logic                 dig_valid,
	input  logic                 dig_stall,
	output logic [31:0]          digest_word,
	output logic [2:0]           word_index,
	output logic                 last_word
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PAD  = 3'd1;
	localparam logic [2:0] S_ZERO = 3'd2;
	localparam logic [2:0] S_LEN  = 3'd3;
	localparam logic [2:0] S_COMP = 3'd4;
	localparam logic [2:0] S_ADD  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]                    state_q, state_n;
	logic [2:0]                    ret_q, ret_n;
	logic [5:0]                    pos_q;
	logic [sha1md_pkg::CNT_W-1:0]  cnt_q;
	logic [63:0]                   len_q;
	logic [sha1md_pkg::RND_W-1:0]  rnd_q;
	logic [2:0]                    oidx_q;
	logic [31:0]                   blk_q [sha1md_pkg::BLK_W];
	logic                          dig_valid_q;
	logic [31:0]                   word_q;
	logic [2:0]                    index_q;
	logic                          last_q;

	logic                          shift;
	logic [7:0]                    sval;
	logic                          go_comp;
	logic                          cnt_inc;
	logic                          cnt_clr;
	logic                          len_load;
	logic                          len_shift;
	logic                          out_load;
	logic [31:0]                   w_new;

	// Sequence requests, padding, rounds and output
	always_comb begin
		// Pick the round phase from the round counter
		if (rnd_q < sha1md_pkg::RND_W'(20)) begin
			ctl.phase = sha1md_pkg::PH_CH;
		end else if (rnd_q < sha1md_pkg::RND_W'(40)) begin
			ctl.phase = sha1md_pkg::PH_PAR;
		end else if (rnd_q < sha1md_pkg::RND_W'(60)) begin
			ctl.phase = sha1md_pkg::PH_MAJ;
		end else begin
			ctl.phase = sha1md_pkg::PH_PR2;
		end
		state_n   = state_q;
		ret_n     = ret_q;
		pop       = 1'b0;
		shift     = 1'b0;
		sval      = '0;
		go_comp   = 1'b0;
		cnt_inc   = 1'b0;
		cnt_clr   = 1'b0;
		len_load  = 1'b0;
		len_shift = 1'b0;
		out_load  = 1'b0;
		ctl.init  = 1'b0;
		ctl.step  = 1'b0;
		ctl.add   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					case (head.kind)
						sha1md_pkg::CMD_BYTE: begin
							shift   = 1'b1;
							sval    = head.data;
							cnt_inc = 1'b1;
							ret_n   = S_IDLE;
							go_comp = (pos_q == 6'd63);
						end
						sha1md_pkg::CMD_BYTE_END: begin
							shift   = 1'b1;
							sval    = head.data;
							cnt_inc = 1'b1;
							ret_n   = S_PAD;
							go_comp = (pos_q == 6'd63);
							state_n = S_PAD;
						end
						sha1md_pkg::CMD_END: begin
							state_n = S_PAD;
						end
						default: begin
						end
					endcase
				end
			end
			S_PAD: begin
				shift    = 1'b1;
				sval     = sha1md_pkg::PAD_BYTE;
				len_load = 1'b1;
				cnt_clr  = 1'b1;
				ret_n    = S_ZERO;
				go_comp  = (pos_q == 6'd63);
				state_n  = S_ZERO;
			end
			S_ZERO: begin
				if (pos_q == 6'd56) begin
					state_n = S_LEN;
				end else begin
					shift   = 1'b1;
					ret_n   = S_ZERO;
					go_comp = (pos_q == 6'd63);
				end
			end
			S_LEN: begin
				shift     = 1'b1;
				sval      = len_q[63:56];
				len_shift = 1'b1;
				ret_n     = S_OUT;
				go_comp   = (pos_q == 6'd63);
			end
			S_COMP: begin
				ctl.step = 1'b1;
				if (rnd_q == sha1md_pkg::RND_W'(sha1md_pkg::ROUNDS - 1)) begin
					state_n = S_ADD;
				end
			end
			S_ADD: begin
				ctl.add = 1'b1;
				state_n = ret_q;
			end
			S_OUT: begin
				if (!dig_valid_q || !dig_stall) begin
					out_load = 1'b1;
					if (oidx_q == 3'd4) begin
						ctl.init = 1'b1;
						state_n  = S_IDLE;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
		if (go_comp) begin
			state_n = S_COMP;
		end
		ctl.load = go_comp;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			pos_q   <= '0;
			cnt_q   <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
		end else begin
			state_q <= state_n;
			ret_q   <= ret_n;
			if (shift) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (go_comp) begin
				rnd_q <= '0;
			end else if (ctl.step) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (out_load) begin
				oidx_q <= (oidx_q == 3'd4) ? 3'd0 : oidx_q + 1'b1;
			end
		end
	end

	// Capture the bit length, then hand it out a byte at a time
	always_ff @(posedge clk) begin
		if (len_load) begin
			len_q <= {cnt_q, 3'b000};
		end else if (len_shift) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	// Next schedule word from the window
	assign w_new = blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0];
	assign w     = blk_q[0];

	// Shift bytes into the block window, or roll the schedule by one word
	always_ff @(posedge clk) begin
		if (shift) begin
			for (int j = 0; j < sha1md_pkg::BLK_W - 1; j++) begin
				blk_q[j] <= {blk_q[j][23:0], blk_q[j+1][31:24]};
			end
			blk_q[sha1md_pkg::BLK_W-1] <= {blk_q[sha1md_pkg::BLK_W-1][23:0], sval};
		end else if (ctl.step) begin
			for (int j = 0; j < sha1md_pkg::BLK_W - 1; j++) begin
				blk_q[j] <= blk_q[j+1];
			end
			blk_q[sha1md_pkg::BLK_W-1] <= {w_new[30:0], w_new[31]};
		end
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_valid_q <= 1'b0;
		end else if (out_load) begin
			dig_valid_q <= 1'b1;
		end else if (!dig_stall) begin
			dig_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			word_q  <= chain[oidx_q];
			index_q <= oidx_q;
			last_q  <= (oidx_q == 3'd4);
		end
	end

	assign dig_valid   = dig_valid_q;
	assign digest_word = word_q;
	assign word_index  = index_q;
	assign last_word   = last_q;

endmodule

/* sv/sha1_message_digest_core.sv */
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// SHA-1 digest of a byte stream: a front queue of requests and a back
// sequencer that pads, compresses and emits the five digest words.
// ----------------------------------------------------------------------------
// Throughput: one message byte per back cycle while the back is not busy;
//   the 64th byte of a block starts 80 rounds (one a cycle in the round
//   datapath), then the chain add; the working variables load with that byte.
// End of message: pad and zero bytes (1 to 64, one a cycle), 8 length bytes,
//   rounds per padded block, then one digest word a cycle if not stalled.
// A four-entry request queue lets input continue while the back is busy.
// Reset clears control, queue and byte count and loads the initial chain;
//   the block window holds no reset value and needs no clearing pass.
module sha1_message_digest_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha1md_pkg::cmd_t     head;
	logic                 empty;
	logic                 pop;
	sha1md_pkg::rnd_ctl_t ctl;
	logic [31:0]          w;
	logic [4:0][31:0]     chain;

	// Accept and queue requests
	sha1md_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_stall      (msg_stall),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.head           (head),
		.empty          (empty),
		.pop            (pop)
	);

	// Sequence blocks, padding and output
	sha1md_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.ctl         (ctl),
		.w           (w),
		.chain       (chain),
		.dig_valid   (dig_valid),
		.dig_stall   (dig_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	// Run the rounds
	sha1md_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.w      (w),
		.chain  (chain)
	);

endmodule

/* sim/tb_sha1_message_digest_core.sv */
// ----------------------------------------------------------------------------
// tb_sha1_message_digest_core
// Byte-stream SHA-1 core test: directed messages (empty, short, extreme
// bytes, ignored requests), then random messages whose lengths favour the
// padding boundaries. Runs with gaps on the request side, stalls on the
// digest side, a long digest hold-off and a full drain pause. Every digest
// word is checked against a behavioural SHA-1 computed alongside.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 400;
	localparam int HOLD_CYCLES    = 600;
	localparam int PRINT_LIMIT    = 40;

	localparam logic [31:0]  K_CH  = 32'h5A827999;
	localparam logic [31:0]  K_PAR = 32'h6ED9EBA1;
	localparam logic [31:0]  K_MAJ = 32'h8F1BBCDC;
	localparam logic [31:0]  K_PR2 = 32'hCA62C1D6;
	localparam logic [159:0] SHA1_IV =
		160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
	localparam logic [7:0]   PAD_MARK = 8'h80;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        msg_valid = 1'b0;
	logic        msg_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_valid = 1'b0;
	logic        end_of_message = 1'b0;
	logic        dig_valid;
	logic        dig_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// Behavioural digest state
	logic [31:0] chain_h [5];
	logic [7:0]  block_bytes [64];
	logic [60:0] msg_bytes;
	digest_out_t digest_due [$];

	int mismatch_count = 0;
	int requests_sent  = 0;
	int quiet_cycles   = 0;
	int send_idle_pct  = 0;
	int stall_pct      = 0;
	int hold_left      = 0;
	bit hold_req       = 1'b0;
	int boundary_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

	sha1_message_digest_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_stall      (msg_stall),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.dig_valid      (dig_valid),
		.dig_stall      (dig_stall),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic load_initial_chain();
		for (int i = 0; i < 5; i++)
			chain_h[i] = SHA1_IV[159 - 32 * i -: 32];
		msg_bytes = '0;
	endtask

	// Fold the 64-byte block into the chaining words
	task automatic compress_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4 * i], block_bytes[4 * i + 1],
				block_bytes[4 * i + 2], block_bytes[4 * i + 3]};
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			if (r >= 16)
				w[r % 16] = rotl(w[(r - 3) % 16] ^ w[(r - 8) % 16]
					^ w[(r - 14) % 16] ^ w[r % 16], 1);
			if (r < 20) begin
				f = d ^ (b & (c ^ d));
				k = K_CH;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_PAR;
			end else if (r < 60) begin
				f = (b & c) | (d & (b | c));
				k = K_MAJ;
			end else begin
				f = b ^ c ^ d;
				k = K_PR2;
			end
			t = rotl(a, 5) + f + e + k + w[r % 16];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endtask

	// Apply one accepted request and queue any digest words it produces
	task automatic absorb_request(input logic [7:0] d, input logic bv, input logic eom);
		int pos;
		logic [63:0] bit_len;
		digest_out_t o;
		if (bv) begin
			block_bytes[msg_bytes[5:0]] = d;
			msg_bytes = msg_bytes + 1'b1;
			if (msg_bytes[5:0] == 6'd0)
				compress_block();
		end
		if (eom) begin
			pos = msg_bytes[5:0];
			bit_len = {msg_bytes, 3'b000};
			block_bytes[pos] = PAD_MARK;
			// spill into a second block when the length no longer fits
			if (pos > 55) begin
				for (int i = pos + 1; i < 64; i++)
					block_bytes[i] = 8'h00;
				compress_block();
				for (int i = 0; i < 56; i++)
					block_bytes[i] = 8'h00;
			end else begin
				for (int i = pos + 1; i < 56; i++)
					block_bytes[i] = 8'h00;
			end
			for (int i = 0; i < 8; i++)
				block_bytes[56 + i] = bit_len[63 - 8 * i -: 8];
			compress_block();
			for (int i = 0; i < 5; i++) begin
				o.word  = chain_h[i];
				o.index = 3'(i);
				o.last  = (i == 4);
				digest_due.push_back(o);
			end
			load_initial_chain();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		// keep the log short if everything goes wrong
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Offer one request, with random gaps, and hold it until accepted
	task automatic send_request(input logic [7:0] d, input logic bv, input logic eom);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			msg_valid      <= 1'b0;
			data_byte      <= 8'($urandom);
			byte_valid     <= 1'($urandom);
			end_of_message <= 1'($urandom);
			@(negedge clk);
		end
		msg_valid      <= 1'b1;
		data_byte      <= d;
		byte_valid     <= bv;
		end_of_message <= eom;
		do @(posedge clk); while (msg_stall);
		absorb_request(d, bv, eom);
		if (bv || eom)
			requests_sent++;
		@(negedge clk);
	endtask

	// Send a message of random bytes with the odd ignored request mixed in
	task automatic send_message(input int len, input bit end_with_byte);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 6)
				send_request(8'($urandom), 1'b0, 1'b0);
			send_request(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
		end
		if (!end_with_byte || len == 0)
			send_request(8'($urandom), 1'b0, 1'b1);
	endtask

	// Mostly short messages, often on a padding boundary, now and then long
	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom_range(0, 12);
		else if (r < 8)
			return boundary_lens[$urandom_range(0, 9)];
		return $urandom_range(13, 130);
	endfunction

	task automatic run_random_messages(input int n_requests, input int idle_pct,
		input int stall_in);
		int start_count;
		int left;
		int len;
		send_idle_pct = idle_pct;
		stall_pct = stall_in;
		start_count = requests_sent;
		while (requests_sent - start_count < n_requests) begin
			left = n_requests - (requests_sent - start_count);
			len = pick_length();
			// trim the message to what is left of this phase
			if (len > left - 1)
				len = left - 1;
			send_message(len, 1'($urandom));
		end
	endtask

	task automatic test_directed_vectors();
		send_idle_pct = 0;
		stall_pct = 0;
		// empty message
		send_request(8'hA5, 1'b0, 1'b1);
		// ignored request
		send_request(8'hFF, 1'b0, 1'b0);
		// "abc", end on the last byte
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b1);
		// "abc", separate end
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b0);
		send_request(8'h00, 1'b0, 1'b1);
		// extreme bytes
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hFF, 1'b1, 1'b0);
		send_request(8'hFF, 1'b1, 1'b1);
		send_request(8'h00, 1'b1, 1'b1);
		send_request(8'hFF, 1'b1, 1'b1);
	endtask

	task automatic test_steady_stream();
		run_random_messages(70, 0, 0);
	endtask

	task automatic test_sender_gaps();
		run_random_messages(40, 58, 0);
	endtask

	task automatic test_receiver_stalls();
		run_random_messages(70, 0, 58);
	endtask

	task automatic test_mixed_gaps();
		run_random_messages(40, 24, 24);
	endtask

	// Hold off the digest side while short messages keep arriving
	task automatic test_output_hold();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 8; i++)
			send_message($urandom_range(1, 3), 1'b1);
	endtask

	// Let every digest drain between messages
	task automatic test_drain_pause();
		send_idle_pct = 0;
		stall_pct = 24;
		for (int i = 0; i < 3; i++) begin
			send_message($urandom_range(0, 12), 1'($urandom));
			msg_valid <= 1'b0;
			while (digest_due.size() != 0)
				@(negedge clk);
		end
	endtask

	// Drive the digest stall: long hold-off on request, else random
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			dig_stall <= 1'b1;
		end else begin
			dig_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Check each accepted digest word against the oldest one due
	always @(posedge clk) begin
		digest_out_t want;
		if (arst_n && dig_valid && !dig_stall) begin
			if (digest_due.size() == 0) begin
				report_mismatch("digest word with none due", digest_word, 32'h0);
			end else begin
				want = digest_due.pop_front();
				if (digest_word !== want.word)
					report_mismatch("digest_word", digest_word, want.word);
				if (word_index !== want.index)
					report_mismatch("word_index", 32'(word_index), 32'(want.index));
				if (last_word !== want.last)
					report_mismatch("last_word", 32'(last_word), 32'(want.last));
			end
		end
	end

	// Give up when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((msg_valid && !msg_stall) || (dig_valid && !dig_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		load_initial_chain();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_vectors();
		test_steady_stream();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_gaps();
		test_output_hold();
		test_drain_pause();

		// drain, then let the core settle
		msg_valid <= 1'b0;
		while (digest_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
sv/sha1md_pkg.sv
sv/sha1md_front.sv
sv/sha1md_round.sv
sv/sha1md_back.sv
sv/sha1_message_digest_core.sv
sim/tb_sha1_message_digest_core.sv
